### hdl/sgt_pkg.sv
package sgt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VAL_W        = 32;
  localparam int SIZE_W       = 7;
  localparam int OUT_W        = 80;

  // one cell's view handed to the next cell down the row
  typedef struct packed {
    logic             take;
    logic             occ;
    logic [VAL_W-1:0] value;
  } link_t;

  // gap candidate from the cell at the insertion point
  typedef struct packed {
    logic             bnd;
    logic             ok;
    logic [VAL_W-1:0] gap;
  } gap_t;

endpackage

### hdl/sgt_cell.sv
module sgt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  logic                     ins,
  input  logic [sgt_pkg::VAL_W-1:0] v,
  input  logic [CNT_W-1:0]         count,
  input  sgt_pkg::link_t           prev,
  output sgt_pkg::link_t           nxt,
  output sgt_pkg::gap_t            cand
);
  import sgt_pkg::*;

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;
  logic             occ;
  logic             take;
  logic             has_pred;
  logic [VAL_W-1:0] g_lo;
  logic [VAL_W-1:0] g_hi;
  logic [VAL_W-1:0] pick;

  // a cell is occupied when its index is below the count held
  assign occ  = count > CNT_W'(IDX);
  // takes the new number (or a shifted one) if empty or holding a larger one
  assign take = !occ || ($signed(value_r) > $signed(v));
  assign has_pred = !prev.take && prev.occ;

  // distances are non-negative and below 2^32, so a wrapping subtract is exact
  assign g_lo = v - prev.value;
  assign g_hi = value_r - v;

  always_comb begin
    if (has_pred && occ) begin
      pick = (g_lo < g_hi) ? g_lo : g_hi;
    end else if (has_pred) begin
      pick = g_lo;
    end else begin
      pick = g_hi;
    end
    cand.bnd = take && !prev.take;
    cand.ok  = cand.bnd && (has_pred || occ);
    cand.gap = cand.ok ? pick : '0;
  end

  assign value_nxt = prev.take ? prev.value : v;

  always_ff @(posedge clk) begin
    if (ins && take) begin
      value_r <= value_nxt;
    end
  end

  assign nxt.take  = take;
  assign nxt.occ   = occ;
  assign nxt.value = value_r;

endmodule

### hdl/sgt_chain.sv
module sgt_chain #(
  parameter int CAPACITY = sgt_pkg::CAPACITY_DEF,
  parameter int CNT_W    = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ins,
  input  logic [sgt_pkg::VAL_W-1:0] v,
  input  logic [CNT_W-1:0]          count,
  output sgt_pkg::gap_t             cand
);
  import sgt_pkg::*;

  link_t              links [0:CAPACITY];
  gap_t               cands [0:CAPACITY-1];
  logic [CAPACITY-1:0] bnd_vec;

  assign links[0] = '{take: 1'b0, occ: 1'b0, value: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sgt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ins   (ins),
      .v     (v),
      .count (count),
      .prev  (links[i]),
      .nxt   (links[i+1]),
      .cand  (cands[i])
    );
    assign bnd_vec[i] = cands[i].bnd;
  end

  // only the insertion point drives a non-zero candidate: OR them together
  always_comb begin
    cand = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cand = cand | cands[i];
    end
  end

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ins |-> $onehot(bnd_vec))
    else $error("insertion point not unique");

endmodule

### hdl/span_gap_tracker.sv
// Channel | Dir | Ports                          | Contents
// in      | in  | in_tvalid/in_tready/in_tdata   | one number per request
// out     | out | out_tvalid/out_tready/out_tdata| status, count, spans per request
// cfg     | in  | cfg_wr_en/cfg_wr_data          | max_size, write only
//
// One request per cycle unless out_tready stalls; results pass the gap stage, then the
// result register. The row of cells compares every held number against the new one in
// parallel, shifts larger ones along in the accept cycle; the gap stage updates the gap.
// rst_n is synchronous, active low: count, max_size and the shortest span clear.
// out_tready low holds the result register, then the gap stage, then in_tready drops.
module span_gap_tracker #(
  parameter int CAPACITY = sgt_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sgt_pkg::VAL_W-1:0]   in_tdata,   // [31:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] status, [7:1] count, [8] spans_valid, [40:9] shortest_span,
  // [72:41] longest_span, [79:73] zero
  output logic [sgt_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [sgt_pkg::SIZE_W-1:0]  cfg_wr_data  // [6:0] max_size
);
  import sgt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [SIZE_W-1:0]       max_size_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] least_r, least_nxt;
  logic signed [VAL_W-1:0] greatest_r, greatest_nxt;
  logic [VAL_W-1:0]        best_r, best_nxt;

  // gap stage
  logic                    p1_v_r;
  logic                    p1_status_r;
  logic [CNT_W-1:0]        p1_count_r;
  logic                    p1_cand_ok_r;
  logic [VAL_W-1:0]        p1_cand_r;
  logic signed [VAL_W-1:0] p1_lo_r, p1_hi_r;

  // result register
  logic                    out_v_r;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;

  logic [LIM_W-1:0]        limit;
  logic                    full;
  logic                    acc;
  logic                    ins;
  logic                    adv;
  logic signed [VAL_W-1:0] v;
  gap_t                    cand;
  logic                    spans_ok;
  logic [VAL_W-1:0]        shortest;
  logic [VAL_W-1:0]        longest;

  assign v = $signed(in_tdata);

  // capacity in use saturates at the number of cells
  always_comb begin
    if (LIM_W'(max_size_r) > LIM_W'(CAPACITY)) begin
      limit = LIM_W'(CAPACITY);
    end else begin
      limit = LIM_W'(max_size_r);
    end
  end

  assign full = LIM_W'(count_r) >= limit;
  assign acc  = in_tvalid && in_tready;
  assign ins  = acc && !full;

  // gap stage moves on when the result register is free or being emptied
  assign adv       = p1_v_r && (!out_v_r || out_tready);
  assign in_tready = !p1_v_r || adv;

  sgt_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ins   (ins),
    .v     (in_tdata),
    .count (count_r),
    .cand  (cand)
  );

  // count and extremes move with the insertion
  always_comb begin
    count_nxt    = count_r;
    least_nxt    = least_r;
    greatest_nxt = greatest_r;
    if (ins) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0) begin
        least_nxt    = v;
        greatest_nxt = v;
      end else begin
        if (v < least_r) begin
          least_nxt = v;
        end
        if (v >= greatest_r) begin
          greatest_nxt = v;
        end
      end
    end
  end

  // shortest span: fold the candidate in, then build the result
  always_comb begin
    best_nxt = best_r;
    if (p1_cand_ok_r && (p1_cand_r < best_r)) begin
      best_nxt = p1_cand_r;
    end
    spans_ok = p1_count_r >= CNT_W'(2);
    shortest = spans_ok ? best_nxt : '0;
    longest  = spans_ok ? VAL_W'(p1_hi_r - p1_lo_r) : '0;
    out_data_nxt = '0;
    out_data_nxt[0]     = p1_status_r;
    out_data_nxt[7:1]   = SIZE_W'(p1_count_r);
    out_data_nxt[8]     = spans_ok;
    out_data_nxt[40:9]  = shortest;
    out_data_nxt[72:41] = longest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= '0;
      count_r    <= '0;
      best_r     <= '1;
      p1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_size_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (in_tready) begin
        p1_v_r <= acc;
      end
      if (adv) begin
        best_r  <= best_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    least_r    <= least_nxt;
    greatest_r <= greatest_nxt;
    if (acc) begin
      p1_status_r  <= full;
      p1_count_r   <= count_nxt;
      p1_cand_ok_r <= ins && cand.ok;
      p1_cand_r    <= cand.gap;
      p1_lo_r      <= least_nxt;
      p1_hi_r      <= greatest_nxt;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count beyond cells");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && full) |=> $stable(count_r))
    else $error("rejected request changed count");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not bump count");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && p1_count_r != '0) |-> (p1_lo_r <= p1_hi_r))
    else $error("least above greatest");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Keeps its own sorted copy of the store, predicts one report per accepted
// number and compares the reports that come out of the block against it.
class span_ledger;
  // Layout of out_tdata, highest field first
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] longest;
    logic [31:0] shortest;
    logic        spans_ok;
    logic [6:0]  count;
    logic        rejected;
  } span_report_t;

  logic signed [31:0] held[$];   // ascending
  logic [31:0]        best_gap;
  logic [6:0]         size_limit;
  int                 capacity;
  span_report_t       awaited_reports[$];
  int                 mismatches;

  function new(int cap);
    capacity   = cap;
    best_gap   = '1;
    size_limit = '0;
    mismatches = 0;
  endfunction

  function void set_limit(logic [6:0] v);
    size_limit = v;
  endfunction

  function void narrow_gap(logic [31:0] g);
    if (g < best_gap) best_gap = g;
  endfunction

  // Unsigned distance; hi >= lo, so the 32-bit wrap gives the true value
  function logic [31:0] distance(logic signed [31:0] lo, logic signed [31:0] hi);
    logic [31:0] d;
    d = hi - lo;
    return d;
  endfunction

  function void note_number(logic signed [31:0] v);
    int           limit;
    int           pos;
    int           cnt;
    span_report_t r;
    limit = (size_limit > capacity) ? capacity : size_limit;
    r = '0;
    if (held.size() >= limit) begin
      r.rejected = 1'b1;           // store full: state untouched
    end else begin
      pos = 0;
      while (pos < held.size() && held[pos] <= v) pos++;  // after equal numbers
      if (pos > 0) narrow_gap(distance(held[pos-1], v));
      if (pos < held.size()) narrow_gap(distance(v, held[pos]));
      held.insert(pos, v);
    end
    cnt = held.size();
    r.count = cnt[6:0];
    if (cnt >= 2) begin
      r.spans_ok = 1'b1;
      r.shortest = best_gap;
      r.longest  = distance(held[0], held[cnt-1]);
    end
    awaited_reports = {awaited_reports, r};
  endfunction

  function void check_report(logic [79:0] data);
    span_report_t got;
    span_report_t want;
    bit           bad;
    got = data;
    if (awaited_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report %h with nothing awaited", data);
    end else begin
      want = awaited_reports.pop_front();
      bad = (got.rejected !== want.rejected) || (got.count !== want.count) ||
            (got.spans_ok !== want.spans_ok) || (got.shortest !== want.shortest) ||
            (got.longest !== want.longest) || (got.pad !== want.pad);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("report differs: status %b/%b count %0d/%0d valid %b/%b ",
                 want.rejected, got.rejected, want.count, got.count,
                 want.spans_ok, got.spans_ok);
          $display("shortest %h/%h longest %h/%h pad %h/%h (expected/actual)",
                   want.shortest, got.shortest, want.longest, got.longest,
                   want.pad, got.pad);
        end
      end
    end
  endfunction
endclass

module testbench;
  localparam int CAP       = sgt_pkg::CAPACITY_DEF;
  localparam int ITEMS     = 800;
  localparam int HOLD_LEN  = 60;    // long receiver hold-off, in cycles

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [sgt_pkg::VAL_W-1:0]  in_tdata;   // [31:0] value
  logic                       out_tvalid;
  logic                       out_tready;
  // [0] status, [7:1] count, [8] spans_valid, [40:9] shortest_span,
  // [72:41] longest_span, [79:73] zero
  logic [sgt_pkg::OUT_W-1:0]  out_tdata;
  logic                       cfg_wr_en;
  logic [sgt_pkg::SIZE_W-1:0] cfg_wr_data;  // [6:0] max_size

  span_ledger ledger = new(CAP);

  // sender burst state and the request for a long receiver hold-off
  int burst_left = 0;
  int sent_total = 0;
  bit hold_request = 0;

  span_gap_tracker #(.CAPACITY(CAP)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything is sampled on the edge: inputs were set by NBAs an edge
  // earlier, the block's outputs still hold their pre-edge values here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) ledger.set_limit(cfg_wr_data);
      if (in_tvalid && in_tready) ledger.note_number(in_tdata);
      if (out_tvalid && out_tready) ledger.check_report(out_tdata);
    end
  end

  // Receiver: stall rate changes every so often, from none to heavy.
  // A hold-off request keeps tready low over a HOLD_LEN hold-off so the pipe backs up.
  initial begin
    int stall_pct;
    int mode_left;
    int hold_left;
    stall_pct = 0;
    mode_left = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_LEN - 1;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2:    stall_pct = 20;
            3:    stall_pct = 50;
            default: stall_pct = 85;
          endcase
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Register write; only called with nothing in flight
  task automatic write_limit(input logic [6:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Offer one number, in bursts with random gaps; returns on the accept edge
  task automatic send_number(input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent_total++;
  endtask

  // Stop offering and wait for every awaited report, plus the pipe depth
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (ledger.awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random number: full range, scaled magnitudes, extremes, and late in the
  // fill values close to or equal to ones held. Equal numbers pin the
  // shortest span at zero for good, so they are kept for a nearly full store.
  function automatic logic [31:0] pick_number();
    int                 cnt;
    int                 off;
    logic [31:0]        mag;
    logic signed [31:0] base;
    cnt = ledger.held.size();
    if (cnt >= 56 && $urandom_range(0, 3) == 0)
      return ledger.held[$urandom_range(0, cnt - 1)];
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2, 3: begin
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      4: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000 + $urandom_range(1, 16);
          3: return 32'h7FFF_FFFF - $urandom_range(1, 16);
          4: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        if (cnt < 40) return $urandom;
        base = ledger.held[$urandom_range(0, cnt - 1)];
        off = $urandom_range(1, 64);
        return $urandom_range(0, 1) ? base + off : base - off;
      end
    endcase
  endfunction

  initial begin
    int n;
    int cnt;
    int nxt;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero capacity rejects everything, even the extremes
    write_limit(7'd0);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    drain_reports();

    // One held number: no spans yet, then full
    write_limit(7'd1);
    send_number(32'h0);
    send_number(32'hFFFF_FFFF);
    drain_reports();

    // Both extremes: longest span is all ones, nothing overflows
    write_limit(7'd4);
    send_number(32'h8000_0000);   // in front of the held zero
    send_number(32'h7FFF_FFFF);   // at the back
    send_number(32'h1234_5678);   // in the middle
    send_number(32'h5555_5555);   // store already full at four: rejected
    drain_reports();

    // Capacity lowered below the count: held numbers stay, adds rejected
    write_limit(7'd2);
    send_number(32'hAAAA_AAAA);
    send_number(32'hC000_0001);
    drain_reports();

    // Capacity far above the store acts as the store size
    write_limit(7'd127);
    send_number(32'hEDCB_A987);
    send_number(32'h0000_0001);
    send_number(32'hFFFF_FFFE);
    drain_reports();

    // Random phases. Capacity mostly sits a few above the count so the store
    // fills slowly across the run and most phases mix inserts and rejects.
    n = 0;
    while (sent_total < ITEMS) begin
      cnt = ledger.held.size();
      case ($urandom_range(0, 9))
        0: nxt = 0;
        1: nxt = 127;
        2: nxt = CAP;
        3: nxt = $urandom_range(CAP + 1, 127);
        4: nxt = $urandom_range(0, cnt);
        default: nxt = cnt + $urandom_range(1, 4);
      endcase
      if (nxt > 127) nxt = 127;
      write_limit(nxt[6:0]);
      // back up the pipe on the first phase and now and then after
      if (n == 0 || $urandom_range(0, 7) == 0) begin
        hold_request = 1;
        repeat (30) send_number(pick_number());
      end else begin
        repeat ($urandom_range(8, 40)) send_number(pick_number());
      end
      drain_reports();
      n++;
    end

    // Fill to the store size with capacity saturated, starting with an
    // equal number if there is room for one
    write_limit(7'd127);
    cnt = ledger.held.size();
    if (cnt > 0 && cnt < CAP) send_number(ledger.held[$urandom_range(0, cnt - 1)]);
    repeat (CAP - ledger.held.size() + 10) send_number(pick_number());
    drain_reports();
    repeat (10) @(posedge clk);

    if (ledger.mismatches == 0 && ledger.awaited_reports.size() == 0) begin
      $display("span_gap_tracker: match");
    end else begin
      $display("span_gap_tracker: mismatch");
    end
    $finish;
  end

  // Generous guard against a hung handshake
  initial begin
    #2_000_000;
    $display("span_gap_tracker: mismatch");
    $finish;
  end

endmodule

### sim.f
hdl/sgt_pkg.sv
hdl/sgt_cell.sv
hdl/sgt_chain.sv
hdl/span_gap_tracker.sv
tb/testbench.sv
